// ===== hdl/assert_macros.svh =====
// Assertion macros for the CBOR item counter; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset.
`define CIC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CIC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cic_pkg.sv =====
// Shared constants, types and control structs of the CBOR item counter.
package cic_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_DEPTH);

    localparam logic [7:0] AI_MASK     = 8'h1F;
    localparam int         MAJOR_SHIFT = 5;
    localparam logic [4:0] AI_ONE_BYTE    = 5'd24;
    localparam logic [4:0] AI_TWO_BYTES   = 5'd25;
    localparam logic [4:0] AI_FOUR_BYTES  = 5'd26;
    localparam logic [4:0] AI_EIGHT_BYTES = 5'd27;

    localparam logic [2:0] MAJ_BSTR   = 3'd2;
    localparam logic [2:0] MAJ_TSTR   = 3'd3;
    localparam logic [2:0] MAJ_ARRAY  = 3'd4;
    localparam logic [2:0] MAJ_MAP    = 3'd5;
    localparam logic [2:0] MAJ_TAG    = 3'd6;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_ARGUMENT = 2'd1,
        PH_SKIP     = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DONE = 2'd1,
        EV_PUSH = 2'd2
    } ev_t;

    typedef enum logic [3:0] {
        S_IN   = 4'b0001,
        S_DONE = 4'b0010,
        S_POP  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic take;
        logic push;
        logic dec;
        logic pop;
        logic load_top;
        logic emit;
        logic emit_ovf;
    } cmd_t;

    typedef struct packed {
        ev_t  ev;
        logic level_full;
        logic level_zero;
        logic level_one;
        logic top_closes;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/cic_in_if.sv =====
// Input byte channel of the CBOR item counter.
interface cic_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_buffer;

    modport source (output valid, output data_byte, output start_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input start_of_buffer, output ready);
endinterface

// ===== hdl/cic_out_if.sv =====
// Result channel of the CBOR item counter.
interface cic_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] item_count;
    logic        depth_overflow;

    modport source (output valid, output item_count, output depth_overflow, input ready);
    modport sink   (input valid, input item_count, input depth_overflow, output ready);
endinterface

// ===== hdl/cic_ctrl.sv =====
// Sequencer: byte intake, level close/pop steps and result emission.
module cic_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cic_pkg::status_t st,
    output cic_pkg::cmd_t    cmd
);
    import cic_pkg::*;

    state_t state_reg, state_next;
    logic   ovf_reg, ovf_next;

    always_comb
    begin
        state_next = state_reg;
        ovf_next   = ovf_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IN);
        case (state_reg)
            S_IN:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    case (st.ev)
                        EV_DONE: state_next = S_DONE;
                        EV_PUSH:
                        begin
                            if (st.level_full)
                            begin
                                ovf_next   = 1'b1;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                        default: state_next = S_IN;
                    endcase
                end
            end
            S_DONE:
            begin
                if (st.level_zero)
                begin
                    ovf_next   = 1'b0;
                    state_next = S_EMIT;
                end
                else if (st.top_closes)
                begin
                    cmd.pop    = 1'b1;
                    state_next = st.level_one ? S_DONE : S_POP;
                end
                else
                begin
                    cmd.dec    = 1'b1;
                    state_next = S_IN;
                end
            end
            S_POP:
            begin
                cmd.load_top = 1'b1;
                state_next   = S_DONE;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_ovf = ovf_reg;
                    state_next   = S_IN;
                end
            end
            default: state_next = S_IN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ===== hdl/cic_datapath.sv =====
// Header decode, argument/skip counters, level stack and result register.
module cic_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  logic             start_of_buffer,
    input  cic_pkg::cmd_t    cmd,
    output cic_pkg::status_t st,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      item_count,
    output logic             depth_overflow
);
    import cic_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [2:0]        major_reg, major_next;
    logic [63:0]       accum_reg, accum_next;
    logic [3:0]        bytes_reg, bytes_next;
    logic [63:0]       skip_reg, skip_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [31:0]       count_reg, count_next;
    logic [63:0]       top_rem_reg, top_rem_next;
    logic              top_half_reg, top_half_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_count_reg;
    logic              out_ovf_reg;
    logic [64:0]       rd_data_reg;
    logic [64:0]       stack_mem [MAX_DEPTH];

    // decode of the offered byte
    phase_t            phase_eff, t_phase;
    logic [LVL_W-1:0]  level_eff, level_m1, level_m2;
    logic [31:0]       count_eff, t_count;
    logic [2:0]        hdr_major, arg_major, t_major;
    logic [4:0]        low5;
    logic [63:0]       t_accum, t_skip, acc_shift, arg_n, push_rem;
    logic [3:0]        t_bytes;
    logic              arg_go, push_half;
    ev_t               ev;
    logic [IDX_W-1:0]  wr_idx, rd_idx;

    assign phase_eff = start_of_buffer ? PH_HEADER : phase_reg;
    assign level_eff = start_of_buffer ? '0 : level_reg;
    assign count_eff = start_of_buffer ? 32'd0 : count_reg;
    assign hdr_major = 3'(data_byte >> MAJOR_SHIFT);
    assign low5      = 5'(data_byte & AI_MASK);
    assign acc_shift = {accum_reg[55:0], data_byte};
    assign level_m1  = level_eff - LVL_W'(1);
    assign level_m2  = level_reg - LVL_W'(2);
    assign wr_idx    = level_m1[IDX_W-1:0];
    assign rd_idx    = level_m2[IDX_W-1:0];

    always_comb
    begin
        t_phase   = phase_eff;
        t_major   = major_reg;
        t_accum   = accum_reg;
        t_bytes   = bytes_reg;
        t_skip    = skip_reg;
        t_count   = count_eff;
        arg_go    = 1'b0;
        arg_n     = 64'd0;
        arg_major = major_reg;
        ev        = EV_NONE;
        push_rem  = 64'd0;
        push_half = 1'b0;
        case (phase_eff)
            PH_HEADER:
            begin
                t_count   = count_eff + 32'd1;
                t_major   = hdr_major;
                arg_major = hdr_major;
                if (hdr_major == MAJ_SIMPLE)
                begin
                    if (low5 >= AI_ONE_BYTE && low5 <= AI_EIGHT_BYTES)
                    begin
                        t_skip  = 64'd1 << low5[1:0];
                        t_phase = PH_SKIP;
                    end
                    else
                    begin
                        ev = EV_DONE;
                    end
                end
                else if (low5 < AI_ONE_BYTE)
                begin
                    arg_go = 1'b1;
                    arg_n  = 64'(low5);
                end
                else if (low5 <= AI_EIGHT_BYTES)
                begin
                    t_accum = 64'd0;
                    t_bytes = 4'd1 << low5[1:0];
                    t_phase = PH_ARGUMENT;
                end
                else
                begin
                    arg_go = 1'b1;
                end
            end
            PH_ARGUMENT:
            begin
                t_accum = acc_shift;
                t_bytes = (bytes_reg != 4'd0) ? bytes_reg - 4'd1 : 4'd0;
                if (t_bytes == 4'd0)
                begin
                    arg_go = 1'b1;
                    arg_n  = acc_shift;
                end
            end
            PH_SKIP:
            begin
                t_skip = (skip_reg != 64'd0) ? skip_reg - 64'd1 : 64'd0;
                if (t_skip == 64'd0)
                begin
                    ev = EV_DONE;
                end
            end
            default: t_phase = PH_HEADER;
        endcase

        if (arg_go)
        begin
            case (arg_major)
                MAJ_BSTR, MAJ_TSTR:
                begin
                    if (arg_n != 64'd0)
                    begin
                        t_skip  = arg_n;
                        t_phase = PH_SKIP;
                    end
                    else
                    begin
                        ev = EV_DONE;
                    end
                end
                MAJ_ARRAY:
                begin
                    if (arg_n == 64'd0)
                    begin
                        ev = EV_DONE;
                    end
                    else
                    begin
                        ev        = EV_PUSH;
                        push_rem  = arg_n >> 1;
                        push_half = arg_n[0];
                    end
                end
                MAJ_MAP:
                begin
                    if (arg_n == 64'd0)
                    begin
                        ev = EV_DONE;
                    end
                    else
                    begin
                        ev       = EV_PUSH;
                        push_rem = arg_n;
                    end
                end
                MAJ_TAG:
                begin
                    ev        = EV_PUSH;
                    push_half = 1'b1;
                end
                default: ev = EV_DONE;
            endcase
        end

        if (ev != EV_NONE)
        begin
            t_phase = PH_HEADER;
        end
    end

    assign st.ev         = ev;
    assign st.level_full = (level_eff >= LVL_MAX);
    assign st.level_zero = (level_reg == '0);
    assign st.level_one  = (level_reg == LVL_W'(1));
    assign st.top_closes = top_half_reg && (top_rem_reg == 64'd0);
    assign st.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        phase_next     = phase_reg;
        major_next     = major_reg;
        accum_next     = accum_reg;
        bytes_next     = bytes_reg;
        skip_next      = skip_reg;
        level_next     = level_reg;
        count_next     = count_reg;
        top_rem_next   = top_rem_reg;
        top_half_next  = top_half_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.take)
        begin
            phase_next = t_phase;
            major_next = t_major;
            accum_next = t_accum;
            bytes_next = t_bytes;
            skip_next  = t_skip;
            count_next = t_count;
            level_next = level_eff;
        end
        if (cmd.push)
        begin
            level_next    = level_eff + LVL_W'(1);
            top_rem_next  = push_rem;
            top_half_next = push_half;
        end
        if (cmd.dec)
        begin
            if (top_half_reg)
            begin
                top_half_next = 1'b0;
            end
            else
            begin
                top_rem_next  = top_rem_reg - 64'd1;
                top_half_next = 1'b1;
            end
        end
        if (cmd.pop)
        begin
            level_next = level_reg - LVL_W'(1);
        end
        if (cmd.load_top)
        begin
            top_rem_next  = rd_data_reg[64:1];
            top_half_next = rd_data_reg[0];
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            phase_next     = PH_HEADER;
            level_next     = '0;
            count_next     = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            major_reg     <= 3'd0;
            accum_reg     <= 64'd0;
            bytes_reg     <= 4'd0;
            skip_reg      <= 64'd0;
            level_reg     <= '0;
            count_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            major_reg     <= major_next;
            accum_reg     <= accum_next;
            bytes_reg     <= bytes_next;
            skip_reg      <= skip_next;
            level_reg     <= level_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_rem_reg  <= top_rem_next;
        top_half_reg <= top_half_next;
        if (cmd.emit)
        begin
            out_count_reg <= count_reg;
            out_ovf_reg   <= cmd.emit_ovf;
        end
    end

    // levels below the top; the top level lives in top_rem/top_half
    always_ff @(posedge clk)
    begin
        if (cmd.push && (level_eff != '0))
        begin
            stack_mem[wr_idx] <= {top_rem_reg, top_half_reg};
        end
        rd_data_reg <= stack_mem[rd_idx];
    end

    assign out_valid      = out_valid_reg;
    assign item_count     = out_count_reg;
    assign depth_overflow = out_ovf_reg;

endmodule

// ===== hdl/cbor_item_counter.sv =====
// CBOR item counter: counts the data items of each top-level item in a byte stream.
//
// stream: one byte of encoded CBOR per beat; start_of_buffer on a beat clears
//   the parser before that byte is decoded.
// result: one beat per finished top-level item with item_count (wraps mod 2^32)
//   and depth_overflow = 0, or, when a container or tag would open a level past
//   MAX_DEPTH, a beat with depth_overflow = 1 and the count so far; the
//   parser then starts over.
// Throughput: one byte per cycle while the sequencer is in S_IN. A byte that ends
//   an item adds a close step in S_DONE, plus a pop and a reload of the new top
//   (S_POP) for each level it closes that has another open below it. Ending the
//   top-level item adds a pop for the outermost level, if any, and the result write
//   in S_EMIT, which waits until the output register is free; a byte that overflows
//   the stack goes straight to S_EMIT, which loads the result into the output register.
// The output register lets bytes keep flowing while a result waits; a second
//   result holds off the input until the first is taken.
// Reset: asynchronous, active low; parser empty, no result pending. The level
//   stack needs no clearing, entries are written before they are read.
module cbor_item_counter (
    input  logic      clk,
    input  logic      rst_n,
    cic_in_if.sink    stream,
    cic_out_if.source result
);
    import cic_pkg::*;

    `include "assert_macros.svh"

    cmd_t    cmd;
    status_t st;

    cic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_ready (stream.ready),
        .st       (st),
        .cmd      (cmd)
    );

    cic_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .data_byte       (stream.data_byte),
        .start_of_buffer (stream.start_of_buffer),
        .cmd             (cmd),
        .st              (st),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .item_count      (result.item_count),
        .depth_overflow  (result.depth_overflow)
    );

    `CIC_ASSERT_IMPL(a_push_room, cmd.push, !st.level_full, "push into a full level stack")
    `CIC_ASSERT_IMPL(a_pop_open, cmd.pop, !st.level_zero, "pop with no open level")
    `CIC_ASSERT(a_take_alone, !(cmd.take && (cmd.dec || cmd.pop || cmd.emit)), "take overlaps step")
    `CIC_ASSERT_NEXT(a_emit_out, cmd.emit, result.valid && stream.ready, "emit lost or stalled")

endmodule

// ===== tb/tb_top.sv =====
// Testbench for cbor_item_counter: streams CBOR bytes, predicts item counts and checks results.
module tb_top;
    import cic_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_BEATS = 1125;

    typedef struct {
        logic [7:0] data;
        bit         sob;
    } beat_t;

    typedef struct {
        logic [31:0] count;
        logic        ovf;
    } tally_t;

    logic clk;
    logic rst_n;

    cic_in_if  stream_ch ();
    cic_out_if result_ch ();

    cbor_item_counter uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    // scanner state mirrored for prediction
    phase_t      ph;
    logic [2:0]  maj;
    logic [63:0] arg_acc;
    int unsigned arg_left;
    logic [63:0] skip_left;
    logic [63:0] lvl_pairs [MAX_DEPTH];
    logic        lvl_odd   [MAX_DEPTH];
    int unsigned lvl_open;
    logic [31:0] hdr_count;

    tally_t due_tallies[$];
    beat_t  beats[$];
    int     errors;
    int     random_beats;
    int     burst_left;
    bit     steady;
    bit     need_sync;
    bit     hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still due", CYCLE_LIMIT,
                 due_tallies.size());
        $display("** cbor_item_counter: FAILED **");
        $finish;
    end

    // ---------------- prediction ----------------

    function automatic void clear_scan();
        ph        = PH_HEADER;
        maj       = 3'd0;
        arg_acc   = 64'd0;
        arg_left  = 0;
        skip_left = 64'd0;
        lvl_open  = 0;
        hdr_count = 32'd0;
    endfunction

    function automatic void post_tally(logic ovf);
        tally_t t;
        t.count = hdr_count;
        t.ovf   = ovf;
        due_tallies.push_back(t);
        clear_scan();
    endfunction

    function automatic void close_item();
        int  top;
        bit  busy;
        busy = 1'b1;
        ph   = PH_HEADER;
        while (busy)
        begin
            if (lvl_open == 0)
            begin
                post_tally(1'b0);
                busy = 1'b0;
            end
            else
            begin
                top = lvl_open - 1;
                if (lvl_odd[top])
                begin
                    lvl_odd[top] = 1'b0;
                end
                else
                begin
                    lvl_pairs[top] = lvl_pairs[top] - 64'd1;
                    lvl_odd[top]   = 1'b1;
                end
                if (lvl_pairs[top] != 64'd0 || lvl_odd[top])
                    busy = 1'b0;
                else
                    lvl_open--;
            end
        end
    endfunction

    function automatic void open_level(logic [63:0] pairs, logic odd);
        if (lvl_open >= MAX_DEPTH)
        begin
            post_tally(1'b1);
        end
        else
        begin
            lvl_pairs[lvl_open] = pairs;
            lvl_odd[lvl_open]   = odd;
            lvl_open++;
            ph = PH_HEADER;
        end
    endfunction

    function automatic void arg_done(logic [63:0] n);
        case (maj)
            MAJ_BSTR, MAJ_TSTR:
            begin
                if (n != 64'd0)
                begin
                    skip_left = n;
                    ph        = PH_SKIP;
                end
                else
                    close_item();
            end
            MAJ_ARRAY:
            begin
                if (n == 64'd0)
                    close_item();
                else
                    open_level(n >> 1, n[0]);
            end
            MAJ_MAP:
            begin
                if (n == 64'd0)
                    close_item();
                else
                    open_level(n, 1'b0);
            end
            MAJ_TAG:
                open_level(64'd0, 1'b1);
            default:
                close_item();
        endcase
    endfunction

    function automatic void scan_byte(logic [7:0] b, bit sob);
        logic [4:0] ai;
        if (sob)
            clear_scan();
        case (ph)
            PH_ARGUMENT:
            begin
                arg_acc = {arg_acc[55:0], b};
                if (arg_left > 0)
                    arg_left--;
                if (arg_left == 0)
                    arg_done(arg_acc);
            end
            PH_SKIP:
            begin
                if (skip_left != 64'd0)
                    skip_left = skip_left - 64'd1;
                if (skip_left == 64'd0)
                    close_item();
            end
            default:
            begin
                hdr_count = hdr_count + 32'd1;
                maj       = b[7:5];
                ai        = b[4:0];
                if (maj == MAJ_SIMPLE)
                begin
                    if (ai >= AI_ONE_BYTE && ai <= AI_EIGHT_BYTES)
                    begin
                        skip_left = 64'd1 << (ai - AI_ONE_BYTE);
                        ph        = PH_SKIP;
                    end
                    else
                        close_item();
                end
                else if (ai < AI_ONE_BYTE)
                    arg_done({59'd0, ai});
                else if (ai <= AI_EIGHT_BYTES)
                begin
                    arg_acc  = 64'd0;
                    arg_left = 1 << (ai - AI_ONE_BYTE);
                    ph       = PH_ARGUMENT;
                end
                else
                    arg_done(64'd0);
            end
        endcase
    endfunction

    // ---------------- byte stream building ----------------

    function automatic void put(logic [7:0] b, bit sob = 1'b0);
        beat_t bt;
        bt.data = b;
        bt.sob  = sob;
        beats.push_back(bt);
    endfunction

    function automatic void put_be(logic [63:0] v, int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            put(v[8*i +: 8]);
    endfunction

    function automatic void put_head(logic [2:0] major, logic [63:0] v);
        int f;
        if (v < 64'd24)
            f = 0;
        else if (v < 64'd256)
            f = 1;
        else if (v < 64'd65536)
            f = 2;
        else if (v < 64'h1_0000_0000)
            f = 3;
        else
            f = 4;
        if ($urandom_range(0, 3) == 0)
            f = $urandom_range(f, 4);
        if (f == 0)
        begin
            put({major, v[4:0]});
        end
        else
        begin
            put({major, 5'(AI_ONE_BYTE + f - 1)});
            put_be(v, 1 << (f - 1));
        end
    endfunction

    function automatic void gen_item(int depth);
        int          kind;
        int          n;
        logic [2:0]  major;
        logic [4:0]  ai;
        logic [63:0] v;
        kind = (depth >= 8) ? $urandom_range(0, 4) : $urandom_range(0, 15);
        if (kind <= 2)
        begin
            major = 3'($urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0)
                put({major, 5'(28 + $urandom_range(0, 3))});
            else
            begin
                v = {$urandom, $urandom} >> $urandom_range(0, 63);
                put_head(major, v);
            end
        end
        else if (kind <= 4)
        begin
            major = (kind == 3) ? MAJ_BSTR : MAJ_TSTR;
            if ($urandom_range(0, 7) == 0)
                put({major, 5'd31});
            else
            begin
                n = $urandom_range(0, 6);
                put_head(major, 64'(n));
                repeat (n) put(8'($urandom_range(0, 255)));
            end
        end
        else if (kind <= 9)
        begin
            major = (kind <= 7) ? MAJ_ARRAY : MAJ_MAP;
            if ($urandom_range(0, 7) == 0)
                put({major, 5'd31});
            else
            begin
                n = (depth >= 4) ? $urandom_range(0, 1)
                  : $urandom_range(0, (major == MAJ_MAP) ? 2 : 3);
                put_head(major, 64'(n));
                if (major == MAJ_MAP)
                    n = 2 * n;
                repeat (n) gen_item(depth + 1);
            end
        end
        else if (kind <= 11)
        begin
            if ($urandom_range(0, 7) == 0)
                put({MAJ_TAG, 5'(28 + $urandom_range(0, 3))});
            else
                put_head(MAJ_TAG, {$urandom, $urandom} >> $urandom_range(0, 63));
            gen_item(depth + 1);
        end
        else
        begin
            ai = 5'($urandom_range(0, 31));
            put({MAJ_SIMPLE, ai});
            if (ai >= AI_ONE_BYTE && ai <= AI_EIGHT_BYTES)
                repeat (1 << (ai - AI_ONE_BYTE)) put(8'($urandom_range(0, 255)));
        end
    endfunction

    // nest close to or past the stack depth, closing maps on the way out
    function automatic void gen_deep();
        int levels;
        bit is_map[$];
        levels = $urandom_range(28, 34);
        for (int i = 0; i < levels; i++)
        begin
            case ($urandom_range(0, 2))
                0:       begin put(8'h81); is_map.push_back(1'b0); end
                1:       begin put(8'hA1); is_map.push_back(1'b1); end
                default: begin put({MAJ_TAG, 5'($urandom_range(0, 23))}); is_map.push_back(1'b0); end
            endcase
        end
        put(8'($urandom_range(0, 23)));
        for (int i = levels - 1; i >= 0; i--)
            if (is_map[i])
                put(8'($urandom_range(0, 23)));
    endfunction

    // ---------------- stream driver ----------------

    task automatic send_beat(logic [7:0] b, bit sob);
        int gap;
        if (!steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                stream_ch.valid           <= 1'b0;
                stream_ch.data_byte       <= 8'($urandom_range(0, 255));
                stream_ch.start_of_buffer <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        stream_ch.valid           <= 1'b1;
        stream_ch.data_byte       <= b;
        stream_ch.start_of_buffer <= sob;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        scan_byte(b, sob);
    endtask

    task automatic send_beats();
        foreach (beats[i])
            send_beat(beats[i].data, beats[i].sob);
        beats.delete();
    endtask

    // ---------------- result checking and receiver stalls ----------------

    task automatic check_result();
        tally_t t;
        if (due_tallies.size() == 0)
        begin
            $display("%0t: result with none due: item_count %0d depth_overflow %0b", $time,
                     result_ch.item_count, result_ch.depth_overflow);
            errors++;
        end
        else
        begin
            t = due_tallies.pop_front();
            if (result_ch.item_count !== t.count)
            begin
                $display("%0t: item_count expected %0d, got %0d", $time, t.count,
                         result_ch.item_count);
                errors++;
            end
            if (result_ch.depth_overflow !== t.ovf)
            begin
                $display("%0t: depth_overflow expected %0b, got %0b", $time, t.ovf,
                         result_ch.depth_overflow);
                errors++;
            end
        end
    endtask

    initial
    begin : receiver
        int hold_left;
        int pat_mode;
        int pat_left;
        hold_left = 0;
        pat_mode  = 0;
        pat_left  = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                check_result();
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(8, 80);
                end
                pat_left--;
                case (pat_mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= 1'b0;
                endcase
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_headers();
        put(8'h00, 1'b1);
        put(8'h17);
        put(8'h18); put(8'hFF);
        put(8'h19); put_be(64'h1234, 2);
        put(8'h1B); put_be('1, 8);
        put(8'h1C);
        put(8'h3F);
        send_beats();
    endtask

    task automatic test_strings();
        put(8'h40);
        put(8'h63); put(8'h61); put(8'h62); put(8'h63);
        put(8'h7F);
        put(8'h5B); put_be(64'd2, 8); put(8'h00); put(8'hFF);
        send_beats();
    endtask

    task automatic test_containers();
        put(8'h80);
        put(8'h9F);
        put(8'hBF);
        put(8'h83); put(8'h01); put(8'h02); put(8'h03);
        put(8'hA2); put(8'h01); put(8'h02); put(8'h03); put(8'h04);
        put(8'hA1); put(8'h81); put(8'h00); put(8'h20);
        put(8'hC0); put(8'h60);
        put(8'hDC); put(8'h00);
        put(8'h81); put(8'h81); put(8'h81); put(8'h00);
        put(8'h98); put(8'h02); put(8'h00); put(8'h00);
        send_beats();
    endtask

    task automatic test_simple();
        put(8'hF4);
        put(8'hF7);
        put(8'hF8); put(8'h20);
        put(8'hF9); put_be(64'h7C00, 2);
        put(8'hFA); put_be(64'h7F80_0000, 4);
        put(8'hFB); put_be('1, 8);
        put(8'hFF);
        put(8'hFC);
        send_beats();
    endtask

    // restart in the middle of a container, an argument and a payload
    task automatic test_restart();
        put(8'h83); put(8'h01); put(8'h02, 1'b1);
        put(8'h19); put(8'h01); put(8'h05, 1'b1);
        put(8'h45); put(8'h01); put(8'h00, 1'b1);
        put(8'h9B); put_be('1, 8); put(8'h00); put(8'h00);
        put(8'hBB); put_be('1, 8); put(8'h01);
        put(8'h00, 1'b1);
        put(8'h01, 1'b1);
        send_beats();
    endtask

    task automatic test_depth();
        repeat (MAX_DEPTH) put(8'h81);
        put(8'h00);
        repeat (MAX_DEPTH + 1) put(8'h81);
        put(8'h00);
        repeat (MAX_DEPTH) put(8'hC0);
        put(8'hA1);
        put(8'h00);
        repeat (MAX_DEPTH) put(8'hA1);
        put(8'h00);
        repeat (MAX_DEPTH + 1) put(8'h01);
        send_beats();
    endtask

    task automatic test_backpressure();
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (40) put(8'($urandom_range(0, 23)));
        send_beats();
        steady = 1'b0;
    endtask

    task automatic test_random();
        int first;
        int len;
        int sel;
        while (random_beats < RANDOM_BEATS)
        begin
            first  = beats.size();
            sel    = $urandom_range(0, 99);
            steady = ($urandom_range(0, 15) == 0);
            if (sel < 82)
            begin
                gen_item(0);
            end
            else if (sel < 86)
            begin
                gen_deep();
            end
            else if (sel < 93)
            begin
                repeat ($urandom_range(1, 6))
                    put(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            else
            begin
                gen_item(0);
                len = beats.size() - first;
                if (len > 1)
                    repeat ($urandom_range(1, len - 1)) void'(beats.pop_back());
            end
            if (need_sync || $urandom_range(0, 7) == 0)
                beats[first].sob = 1'b1;
            need_sync = (sel >= 82);
            random_beats += beats.size();
            send_beats();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n                     <= 1'b0;
        stream_ch.valid           <= 1'b0;
        stream_ch.data_byte       <= 8'h00;
        stream_ch.start_of_buffer <= 1'b0;
        errors       = 0;
        random_beats = 0;
        burst_left   = 0;
        steady       = 1'b0;
        need_sync    = 1'b0;
        hold_req     = 1'b0;
        clear_scan();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_headers();
        test_strings();
        test_containers();
        test_simple();
        test_restart();
        test_depth();
        test_backpressure();
        test_random();

        stream_ch.valid <= 1'b0;
        while (due_tallies.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("** cbor_item_counter: PASSED **");
        else
            $display("** cbor_item_counter: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cic_pkg.sv
hdl/cic_in_if.sv
hdl/cic_out_if.sv
hdl/cic_ctrl.sv
hdl/cic_datapath.sv
hdl/cbor_item_counter.sv
tb/tb_top.sv
